// ===== sv/lfpd_pkg.sv =====
// shared types, constants and widths of the line follower pd drive block
`timescale 1ns / 1ps

package lfpd_pkg;

  // sensor front end geometry
  localparam int SENSOR_COUNT   = 4;
  localparam int SAMPLE_W       = 12;
  localparam int WEIGHT_STEP    = 1000;
  localparam int CENTRE         = ((SENSOR_COUNT - 1) * WEIGHT_STEP) / 2;

  // datapath widths
  localparam int WSUM_W         = 25;
  localparam int SUM_W          = 14;
  localparam int POS_W          = 12;
  localparam int ERR_W          = 12;
  localparam int LEVEL_W        = 8;
  localparam int CORR_W         = 23;
  localparam int DIV_W          = SUM_W + POS_W - 1;

  // queue between front end and back end
  localparam int QUEUE_DEPTH_DEF = 4;

  // configuration register indexes
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] CFG_PROP_GAIN    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_DERIV_GAIN   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_CRUISE_SPEED = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_FLOOR_SPEED  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_LEFT_LIMIT   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_RIGHT_LIMIT  = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_SLOW_DIVISOR = 3'd6;

  // input word: one frame of raw samples
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_a;
    logic [SAMPLE_W-1:0] sample_b;
    logic [SAMPLE_W-1:0] sample_c;
    logic [SAMPLE_W-1:0] sample_d;
  } in_word_t;

  // output word: drive levels and line position
  typedef struct packed {
    logic [LEVEL_W-1:0] left_drive;
    logic [LEVEL_W-1:0] right_drive;
    logic [POS_W-1:0]   line_position;
  } out_word_t;

  // configuration register file
  typedef struct packed {
    logic [LEVEL_W-1:0] prop_gain;
    logic [LEVEL_W-1:0] deriv_gain;
    logic [LEVEL_W-1:0] cruise_speed;
    logic [LEVEL_W-1:0] floor_speed;
    logic [LEVEL_W-1:0] left_limit;
    logic [LEVEL_W-1:0] right_limit;
    logic [LEVEL_W-1:0] slow_divisor;
  } cfg_t;

  // queue entry: centroid numerator and denominator
  typedef struct packed {
    logic [WSUM_W-1:0] wsum;
    logic [SUM_W-1:0]  sum;
  } q_entry_t;

  // shared divider request and response
  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [SUM_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [POS_W-1:0] quotient;
  } div_rsp_t;

  // back end sequencer
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_POS,
    BK_ERR,
    BK_SLOW,
    BK_DRIVE
  } back_state_t;

endpackage

// ===== sv/lfpd_front.sv =====
// front end: takes sample words and forms weighted and plain sums
`timescale 1ns / 1ps

module lfpd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  lfpd_pkg::in_word_t  in_word,
  output logic                q_push,
  output lfpd_pkg::q_entry_t  q_word,
  input  logic                q_full
);
  import lfpd_pkg::*;

  logic     valid_r, valid_nxt;
  q_entry_t word_r;
  q_entry_t word_nxt;
  logic     accept;
  logic [SAMPLE_W-1:0] v_a, v_b, v_c, v_d;

  // inverted samples
  assign v_a = ~in_word.sample_a;
  assign v_b = ~in_word.sample_b;
  assign v_c = ~in_word.sample_c;
  assign v_d = ~in_word.sample_d;

  // weighted and plain sums of one frame
  always_comb begin
    word_nxt.wsum = WSUM_W'(v_b) * WSUM_W'(WEIGHT_STEP)
                  + WSUM_W'(v_c) * WSUM_W'(2 * WEIGHT_STEP)
                  + WSUM_W'(v_d) * WSUM_W'(3 * WEIGHT_STEP);
    word_nxt.sum  = SUM_W'(v_a) + SUM_W'(v_b) + SUM_W'(v_c) + SUM_W'(v_d);
  end

  // holding stage in front of the queue
  assign in_full = valid_r & q_full;
  assign accept  = in_push & ~in_full;
  assign q_push  = valid_r;
  assign q_word  = word_r;

  always_comb begin
    valid_nxt = valid_r & q_full;
    if (accept) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word_r <= word_nxt;
    end
  end

endmodule

// ===== sv/lfpd_fifo.sv =====
// short queue between front end and back end
`timescale 1ns / 1ps

module lfpd_fifo #(
  parameter int DEPTH = lfpd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lfpd_pkg::q_entry_t  wr_word,
  output logic                full,
  input  logic                pop,
  output lfpd_pkg::q_entry_t  rd_word,
  output logic                empty
);
  import lfpd_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_entry_t        mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rd_word = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_word;
    end
  end

endmodule

// ===== sv/lfpd_div.sv =====
// restoring divider, one quotient bit per cycle, shared by the back end
`timescale 1ns / 1ps

module lfpd_div (
  input  logic                clk,
  input  logic                rst_n,
  input  lfpd_pkg::div_req_t  req,
  output lfpd_pkg::div_rsp_t  rsp
);
  import lfpd_pkg::*;

  localparam int STEP_W = $clog2(POS_W);

  logic              busy_r, busy_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W-1:0]  den_r, den_nxt;
  logic [POS_W-1:0]  q_r, q_nxt;
  logic              ge;
  logic [POS_W-1:0]  q_step;

  // one compare and subtract per cycle
  assign ge     = (rem_r >= den_r);
  assign q_step = {q_r[POS_W-2:0], ge};

  assign rsp.done     = busy_r & (step_r == '0);
  assign rsp.quotient = q_step;

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(POS_W - 1);
      rem_nxt  = req.dividend;
      den_nxt  = DIV_W'(req.divisor) << (POS_W - 1);
      q_nxt    = '0;
    end else if (busy_r) begin
      rem_nxt  = ge ? rem_r - den_r : rem_r;
      den_nxt  = den_r >> 1;
      q_nxt    = q_step;
      step_nxt = step_r - 1'b1;
      if (step_r == '0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    q_r    <= q_nxt;
  end

endmodule

// ===== sv/lfpd_back.sv =====
// back end: centroid divide, pd correction, slowdown and drive clamps
`timescale 1ns / 1ps

module lfpd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  lfpd_pkg::cfg_t      cfg,
  input  lfpd_pkg::q_entry_t  q_word,
  input  logic                q_empty,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output lfpd_pkg::out_word_t out_word
);
  import lfpd_pkg::*;

  back_state_t state_r, state_nxt;
  logic [POS_W-1:0]         pos_r, pos_nxt;
  logic signed [CORR_W-1:0] corr_r, corr_nxt;
  logic signed [ERR_W-1:0]  prev_err_r, prev_err_nxt;
  logic [POS_W-1:0]         slow_q_r, slow_q_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_word_t                out_word_r, out_word_nxt;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic signed [POS_W+1:0]   err_ext;
  logic signed [ERR_W-1:0]   err;
  logic signed [CORR_W-1:0]  err_s, diff_s, kp_s, kd_s, corr;
  logic [ERR_W-1:0]          mag;
  logic [LEVEL_W-1:0]        slow_den;
  logic signed [POS_W+1:0]   base_raw;
  logic [LEVEL_W-1:0]        base;
  logic signed [CORR_W:0]    lsum, rsum;
  logic [LEVEL_W-1:0]        left_lvl, right_lvl;

  lfpd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // position error, saturated to the stored width
  always_comb begin
    err_ext = $signed({2'b00, pos_r}) - (POS_W+2)'(CENTRE);
    if (err_ext < -(POS_W+2)'(2048)) begin
      err = {1'b1, {(ERR_W-1){1'b0}}};
    end else if (err_ext > (POS_W+2)'(2047)) begin
      err = {1'b0, {(ERR_W-1){1'b1}}};
    end else begin
      err = err_ext[ERR_W-1:0];
    end
  end

  // pd correction
  always_comb begin
    err_s  = CORR_W'(err);
    diff_s = CORR_W'(err) - CORR_W'(prev_err_r);
    kp_s   = CORR_W'($signed({1'b0, cfg.prop_gain}));
    kd_s   = CORR_W'($signed({1'b0, cfg.deriv_gain}));
    corr   = kp_s * err_s + kd_s * diff_s;
  end

  // slowdown operands
  assign mag      = err[ERR_W-1] ? ERR_W'(-(ERR_W+1)'(err)) : ERR_W'(err);
  assign slow_den = (cfg.slow_divisor == '0) ? LEVEL_W'(1) : cfg.slow_divisor;

  // slowed base level, low bound tested first
  always_comb begin
    base_raw = $signed({6'b0, cfg.cruise_speed}) - $signed({2'b00, slow_q_r});
    if (base_raw < $signed({6'b0, cfg.floor_speed})) begin
      base = cfg.floor_speed;
    end else if (base_raw > $signed({6'b0, cfg.cruise_speed})) begin
      base = cfg.cruise_speed;
    end else begin
      base = base_raw[LEVEL_W-1:0];
    end
  end

  // drive levels clamped to zero and their limits
  always_comb begin
    lsum = (CORR_W+1)'($signed({1'b0, base})) + (CORR_W+1)'(corr_r);
    rsum = (CORR_W+1)'($signed({1'b0, base})) - (CORR_W+1)'(corr_r);
    if (lsum < 0) begin
      left_lvl = '0;
    end else if (lsum > $signed({{(CORR_W-LEVEL_W+1){1'b0}}, cfg.left_limit})) begin
      left_lvl = cfg.left_limit;
    end else begin
      left_lvl = lsum[LEVEL_W-1:0];
    end
    if (rsum < 0) begin
      right_lvl = '0;
    end else if (rsum > $signed({{(CORR_W-LEVEL_W+1){1'b0}}, cfg.right_limit})) begin
      right_lvl = cfg.right_limit;
    end else begin
      right_lvl = rsum[LEVEL_W-1:0];
    end
  end

  // sequencer: next state and outputs
  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    corr_nxt      = corr_r;
    prev_err_nxt  = prev_err_r;
    slow_q_nxt    = slow_q_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    q_pop         = 1'b0;
    div_req       = '0;
    if (out_pop && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_word.sum == '0) begin
            pos_nxt   = POS_W'(CENTRE);
            state_nxt = BK_ERR;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(q_word.wsum);
            div_req.divisor  = q_word.sum;
            state_nxt        = BK_POS;
          end
        end
      end
      BK_POS: begin
        if (div_rsp.done) begin
          pos_nxt   = div_rsp.quotient;
          state_nxt = BK_ERR;
        end
      end
      BK_ERR: begin
        corr_nxt         = corr;
        prev_err_nxt     = err;
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(mag);
        div_req.divisor  = SUM_W'(slow_den);
        state_nxt        = BK_SLOW;
      end
      BK_SLOW: begin
        if (div_rsp.done) begin
          slow_q_nxt = div_rsp.quotient;
          state_nxt  = BK_DRIVE;
        end
      end
      BK_DRIVE: begin
        if (!out_valid_r || out_pop) begin
          out_valid_nxt              = 1'b1;
          out_word_nxt.left_drive    = left_lvl;
          out_word_nxt.right_drive   = right_lvl;
          out_word_nxt.line_position = pos_r;
          state_nxt                  = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      prev_err_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      prev_err_r  <= prev_err_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    corr_r     <= corr_nxt;
    slow_q_r   <= slow_q_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_empty = ~out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== sv/line_follower_pd_drive_top.sv =====
// top level of the pd line follower drive block
`timescale 1ns / 1ps

// Each sample word becomes one result word. The front end takes a word and forms the
// weighted and plain sums; the back end then works through each word in turn (pop, 12
// divider steps for the centroid, error and pd correction, 12 divider steps for the curve
// slowdown, drive clamp), skipping the centroid divide when every sample reads full scale.
// The shared one-bit-per-cycle divider serves both divides, and the back end takes no new
// word until the last result is in the output register. Up to QUEUE_DEPTH words plus one
// held in the front end can wait ahead of the back end, and a finished result waits in an
// output register while the next word is worked on. Configuration writes are taken every
// cycle and should only be issued while no word is in flight.
module line_follower_pd_drive_top #(
  parameter int QUEUE_DEPTH = lfpd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  lfpd_pkg::in_word_t                  in_word,
  output logic                                out_empty,
  input  logic                                out_pop,
  output lfpd_pkg::out_word_t                 out_word,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lfpd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [lfpd_pkg::LEVEL_W-1:0]        cfg_data
);
  import lfpd_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  logic     q_push, q_full, q_pop, q_empty;
  q_entry_t q_wr_word, q_rd_word;

  // configuration register file
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_addr)
        CFG_PROP_GAIN:    cfg_nxt.prop_gain    = cfg_data;
        CFG_DERIV_GAIN:   cfg_nxt.deriv_gain   = cfg_data;
        CFG_CRUISE_SPEED: cfg_nxt.cruise_speed = cfg_data;
        CFG_FLOOR_SPEED:  cfg_nxt.floor_speed  = cfg_data;
        CFG_LEFT_LIMIT:   cfg_nxt.left_limit   = cfg_data;
        CFG_RIGHT_LIMIT:  cfg_nxt.right_limit  = cfg_data;
        CFG_SLOW_DIVISOR: cfg_nxt.slow_divisor = cfg_data;
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain    <= LEVEL_W'(2);
      cfg_r.deriv_gain   <= LEVEL_W'(5);
      cfg_r.cruise_speed <= LEVEL_W'(100);
      cfg_r.floor_speed  <= LEVEL_W'(80);
      cfg_r.left_limit   <= LEVEL_W'(120);
      cfg_r.right_limit  <= LEVEL_W'(120);
      cfg_r.slow_divisor <= LEVEL_W'(12);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front end
  lfpd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_word (in_word),
    .q_push  (q_push),
    .q_word  (q_wr_word),
    .q_full  (q_full)
  );

  // decoupling queue
  lfpd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_word (q_wr_word),
    .full    (q_full),
    .pop     (q_pop),
    .rd_word (q_rd_word),
    .empty   (q_empty)
  );

  // back end
  lfpd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_word    (q_rd_word),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word)
  );

  // an accepted word is held in the front end on the next cycle
  a_front_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full) |=> q_push)
    else $error("accepted word not held in front end");

  // the front end never stalls while the queue has room
  a_no_stall_with_room: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && !q_full) |-> !in_full)
    else $error("front end stalled with queue room");

  // a full queue keeps the front end word until it drains
  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_full) |=> q_push)
    else $error("front end word lost while queue full");

  // the centroid stays inside the sensor span
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_word.line_position <= POS_W'((SENSOR_COUNT - 1) * WEIGHT_STEP)))
    else $error("line position outside sensor span");

endmodule
